// ----- design/pff_pkg.sv -----
`timescale 1ns / 1ps
// pff_pkg: shared widths, codes and types for the plane frame block
// used by pff_front, pff_back and plane_frame_from_points; no dependencies
package pff_pkg;

    // point store and counts
    localparam int MAX_POINTS = 1024;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int MIN_POINTS = 3;

    // coordinate and transaction widths
    localparam int COORD_W  = 32;
    localparam int PT_W     = 3 * COORD_W;
    localparam int UNIT_W   = 32;
    localparam int NUM_UNIT = 6;
    localparam int OUT_W    = 3 * COORD_W + NUM_UNIT * UNIT_W;
    localparam int STATUS_W = 2;

    // arithmetic widths
    localparam int DIFF_W  = COORD_W + 1;
    localparam int VEC_W   = 2 * DIFF_W + 1;
    localparam int PIECE_W = DIFF_W;
    localparam int MUL_W   = VEC_W - PIECE_W;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int SQ_W    = 2 * VEC_W;
    localparam int ACC_W   = SQ_W + 2;
    localparam int REM_W   = SQ_W + 1;
    localparam int QUO_W   = 63;
    localparam int ROOT_W  = QUO_W + 1;

    // sequencer step counts
    localparam int SQ_STEPS    = 9;
    localparam int CROSS_STEPS = 6;
    localparam int DIV_STEPS   = QUO_W;
    localparam int ROOT_STEPS  = ROOT_W / 2;

    // shifts of the partial squares
    localparam int SHIFT_HH = 2 * PIECE_W;
    localparam int SHIFT_HL = PIECE_W + 1;

    // partial square selectors
    localparam logic [1:0] PART_HH = 2'd0;
    localparam logic [1:0] PART_HL = 2'd1;
    localparam logic [1:0] PART_LL = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FEW   = 2'd1,
        ST_DEGEN = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_P1_RD,
        S_P1_LD,
        S_SQ,
        S_P1_CMP,
        S_P2_RD,
        S_P2_LD,
        S_CROSS,
        S_P2_CMP,
        S_FIN,
        S_DV_LD,
        S_DV_SET,
        S_DIV,
        S_RT_SET,
        S_ROOT,
        S_STORE_OUT
    } state_t;

    // one finished point set handed from front to back
    typedef struct packed {
        logic                      valid;
        logic [CNT_W-1:0]          count;
        logic signed [COORD_W-1:0] org_z;
        logic signed [COORD_W-1:0] org_y;
        logic signed [COORD_W-1:0] org_x;
    } job_t;

    // back to front handshake
    typedef struct packed {
        logic pop;
        logic done;
    } back_ctl_t;

endpackage

// ----- design/pff_front.sv -----
`timescale 1ns / 1ps
// pff_front: accepts points, fills the point store and queues one set
// depends on pff_pkg
module pff_front import pff_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [PT_W-1:0]  s_tdata,
    input  logic             s_tlast,
    output job_t             job,
    input  back_ctl_t        ctl,
    input  logic [IDX_W-1:0] rd_addr,
    output logic [PT_W-1:0]  rd_data
);

    logic [PT_W-1:0]  mem [MAX_POINTS];
    logic [PT_W-1:0]  rd_data_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             hold_reg;
    job_t             job_reg;
    logic             accept;
    logic             room;
    logic [CNT_W-1:0] cnt_new;

    assign s_tready = !hold_reg;
    assign accept   = s_tvalid && !hold_reg;
    assign room     = cnt_reg < CNT_W'(MAX_POINTS);
    assign cnt_new  = cnt_reg + CNT_W'(room);
    assign job      = job_reg;
    assign rd_data  = rd_data_reg;

    // point store, one write and one registered read
    always_ff @(posedge aclk) begin
        if (accept && room) begin
            mem[cnt_reg[IDX_W-1:0]] <= s_tdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // count, hold, origin latch and one-deep job queue
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            hold_reg      <= 1'b0;
            job_reg.valid <= 1'b0;
        end else begin
            if (accept && cnt_reg == '0) begin
                job_reg.org_x <= s_tdata[COORD_W-1:0];
                job_reg.org_y <= s_tdata[2*COORD_W-1:COORD_W];
                job_reg.org_z <= s_tdata[3*COORD_W-1:2*COORD_W];
            end
            if (accept) begin
                if (s_tlast) begin
                    cnt_reg       <= '0;
                    hold_reg      <= 1'b1;
                    job_reg.valid <= 1'b1;
                    job_reg.count <= cnt_new;
                end else begin
                    cnt_reg <= cnt_new;
                end
            end
            if (ctl.pop) begin
                job_reg.valid <= 1'b0;
            end
            if (ctl.done) begin
                hold_reg <= 1'b0;
            end
        end
    end

endmodule

// ----- design/pff_back.sv -----
`timescale 1ns / 1ps
// pff_back: searches the stored set and builds axis and normal
// shared multiplier, bit-serial divider and square root; depends on pff_pkg
module pff_back import pff_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  job_t                job,
    output back_ctl_t           ctl,
    output logic [IDX_W-1:0]    rd_addr,
    input  logic [PT_W-1:0]     rd_data,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_W-1:0]    m_tdata,
    output logic [STATUS_W-1:0] m_tuser
);

    state_t state_reg, state_next, ret_reg, ret_next;
    logic [CNT_W-1:0] idx_reg, idx_next, cnt_reg, cnt_next;
    logic [CNT_W-1:0] far_reg, far_next, sec_reg, sec_next;
    logic signed [COORD_W-1:0] org_reg [3];
    logic signed [COORD_W-1:0] org_next [3];
    logic signed [DIFF_W-1:0]  d_reg [3];
    logic signed [DIFF_W-1:0]  d_next [3];
    logic signed [DIFF_W-1:0]  d1_reg [3];
    logic signed [DIFF_W-1:0]  d1_next [3];
    logic signed [VEC_W-1:0]   vec_reg [3];
    logic signed [VEC_W-1:0]   vec_next [3];
    logic signed [VEC_W-1:0]   bc_reg [3];
    logic signed [VEC_W-1:0]   bc_next [3];
    logic signed [UNIT_W-1:0]  unit_reg [NUM_UNIT];
    logic signed [UNIT_W-1:0]  unit_next [NUM_UNIT];
    logic [SQ_W-1:0]   best_reg, best_next, bcross_reg, bcross_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [3:0]        step_reg, step_next;
    logic [1:0]        sq_comp_reg, sq_comp_next, sq_part_reg, sq_part_next;
    logic [1:0]        ppart_reg;
    logic [3:0]        ptag_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [SQ_W-1:0]   div_reg, div_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [5:0]        bit_reg, bit_next;
    logic [ROOT_W-1:0] op_reg, op_next, res_reg, res_next, one_reg, one_next;
    logic [2:0]        comp_reg, comp_next;
    status_t           status_reg, status_next;
    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg;
    status_t           out_status_reg;

    // shared conditions
    logic [CNT_W-1:0] idx_inc;
    logic [SQ_W-1:0]  acc_mag;
    logic             idx_last, p1_win, p2_win, out_free, degen, few, skip;
    logic [2:0]       comp_m3;
    logic signed [VEC_W-1:0] src;
    logic signed [ACC_W-1:0] prod_ext;
    logic signed [MUL_W-1:0] sq_h, sq_l;

    assign idx_inc  = idx_reg + CNT_W'(1);
    assign idx_last = idx_inc == cnt_reg;
    assign acc_mag  = acc_reg[SQ_W-1:0];
    assign p1_win   = (idx_reg == CNT_W'(1)) || (acc_mag > best_reg);
    assign p2_win   = (sec_reg == '0) || (acc_mag > bcross_reg);
    assign out_free = !out_valid_reg || m_tready;
    assign degen    = (best_reg == '0) || (bcross_reg == '0);
    assign few      = job.count < CNT_W'(MIN_POINTS);
    assign skip     = idx_reg == far_reg;
    assign comp_m3  = comp_reg - 3'd3;
    assign src      = (comp_reg < 3'd3)
                    ? VEC_W'(d1_reg[comp_reg[1:0]]) : bc_reg[comp_m3[1:0]];
    assign prod_ext = ACC_W'(prod_reg);
    assign sq_h     = vec_reg[sq_comp_reg][VEC_W-1:PIECE_W];
    assign sq_l     = $signed({1'b0, vec_reg[sq_comp_reg][PIECE_W-1:0]});

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (job.valid) begin
                    state_next = few ? S_STORE_OUT : S_P1_RD;
                end
            end
            S_P1_RD:  state_next = S_P1_LD;
            S_P1_LD:  state_next = S_SQ;
            S_SQ: begin
                if (step_reg == 4'(SQ_STEPS)) begin
                    state_next = ret_reg;
                end
            end
            S_P1_CMP: state_next = idx_last ? S_P2_RD : S_P1_RD;
            S_P2_RD: begin
                if (!skip) begin
                    state_next = S_P2_LD;
                end else if (idx_last) begin
                    state_next = S_FIN;
                end
            end
            S_P2_LD:  state_next = S_CROSS;
            S_CROSS: begin
                if (step_reg == 4'(CROSS_STEPS)) begin
                    state_next = S_SQ;
                end
            end
            S_P2_CMP: state_next = idx_last ? S_FIN : S_P2_RD;
            S_FIN:    state_next = degen ? S_STORE_OUT : S_DV_LD;
            S_DV_LD:  state_next = S_SQ;
            S_DV_SET: state_next = S_DIV;
            S_DIV: begin
                if (bit_reg == 6'(DIV_STEPS - 1)) begin
                    state_next = S_RT_SET;
                end
            end
            S_RT_SET: state_next = S_ROOT;
            S_ROOT: begin
                if (bit_reg == 6'(ROOT_STEPS - 1)) begin
                    state_next = (comp_reg == 3'(NUM_UNIT - 1)) ? S_STORE_OUT : S_DV_LD;
                end
            end
            S_STORE_OUT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SQ: begin
                case (sq_part_reg)
                    PART_HH: begin
                        mul_a = sq_h;
                        mul_b = sq_h;
                    end
                    PART_HL: begin
                        mul_a = sq_h;
                        mul_b = sq_l;
                    end
                    default: begin
                        mul_a = sq_l;
                        mul_b = sq_l;
                    end
                endcase
            end
            S_CROSS: begin
                case (step_reg)
                    4'd0: begin
                        mul_a = MUL_W'(d1_reg[1]);
                        mul_b = MUL_W'(d_reg[2]);
                    end
                    4'd1: begin
                        mul_a = MUL_W'(d1_reg[2]);
                        mul_b = MUL_W'(d_reg[1]);
                    end
                    4'd2: begin
                        mul_a = MUL_W'(d1_reg[2]);
                        mul_b = MUL_W'(d_reg[0]);
                    end
                    4'd3: begin
                        mul_a = MUL_W'(d1_reg[0]);
                        mul_b = MUL_W'(d_reg[2]);
                    end
                    4'd4: begin
                        mul_a = MUL_W'(d1_reg[0]);
                        mul_b = MUL_W'(d_reg[1]);
                    end
                    4'd5: begin
                        mul_a = MUL_W'(d1_reg[1]);
                        mul_b = MUL_W'(d_reg[0]);
                    end
                    default: begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // datapath next values
    always_comb begin
        logic [REM_W-1:0]  trial;
        logic              ge;
        logic [ROOT_W-1:0] rsum;
        logic [33:0]       rnd;
        logic signed [ACC_W-1:0] term;
        logic signed [VEC_W-1:0] pv;
        logic signed [DIFF_W-1:0] pt [3];

        ret_next     = ret_reg;
        idx_next     = idx_reg;
        cnt_next     = cnt_reg;
        far_next     = far_reg;
        sec_next     = sec_reg;
        org_next     = org_reg;
        d_next       = d_reg;
        d1_next      = d1_reg;
        vec_next     = vec_reg;
        bc_next      = bc_reg;
        unit_next    = unit_reg;
        best_next    = best_reg;
        bcross_next  = bcross_reg;
        acc_next     = acc_reg;
        step_next    = step_reg;
        sq_comp_next = sq_comp_reg;
        sq_part_next = sq_part_reg;
        rem_next     = rem_reg;
        div_next     = div_reg;
        quo_next     = quo_reg;
        bit_next     = bit_reg;
        op_next      = op_reg;
        res_next     = res_reg;
        one_next     = one_reg;
        comp_next    = comp_reg;
        status_next  = status_reg;

        // offset of the point just read from the origin
        for (int k = 0; k < 3; k++) begin
            pt[k] = DIFF_W'($signed(rd_data[k*COORD_W +: COORD_W])) - DIFF_W'(org_reg[k]);
        end

        // shifted partial square
        case (ppart_reg)
            PART_HH: term = prod_ext <<< SHIFT_HH;
            PART_HL: term = prod_ext <<< SHIFT_HL;
            default: term = prod_ext;
        endcase
        pv    = $signed(prod_reg[VEC_W-1:0]);
        trial = (bit_reg == '0) ? rem_reg : {rem_reg[REM_W-2:0], 1'b0};
        ge    = trial >= {1'b0, div_reg};
        rsum  = res_reg + one_reg;
        rnd   = {1'b0, res_reg[32:0]} + 34'd1;

        case (state_reg)
            S_IDLE: begin
                if (job.valid) begin
                    cnt_next    = job.count;
                    org_next[0] = job.org_x;
                    org_next[1] = job.org_y;
                    org_next[2] = job.org_z;
                    idx_next    = CNT_W'(1);
                    far_next    = '0;
                    sec_next    = '0;
                    best_next   = '0;
                    bcross_next = '0;
                    for (int k = 0; k < NUM_UNIT; k++) begin
                        unit_next[k] = '0;
                    end
                    status_next = few ? ST_FEW : ST_OK;
                end
            end
            S_P1_LD: begin
                d_next = pt;
                for (int k = 0; k < 3; k++) begin
                    vec_next[k] = VEC_W'(pt[k]);
                end
                step_next    = '0;
                sq_comp_next = '0;
                sq_part_next = PART_HH;
                ret_next     = S_P1_CMP;
            end
            S_SQ: begin
                step_next = step_reg + 4'd1;
                acc_next  = (step_reg == '0) ? '0 : acc_reg + term;
                if (step_reg < 4'(SQ_STEPS - 1)) begin
                    if (sq_part_reg == PART_LL) begin
                        sq_part_next = PART_HH;
                        sq_comp_next = sq_comp_reg + 2'd1;
                    end else begin
                        sq_part_next = sq_part_reg + 2'd1;
                    end
                end
            end
            S_P1_CMP: begin
                if (p1_win) begin
                    best_next = acc_mag;
                    far_next  = idx_reg;
                    d1_next   = d_reg;
                end
                idx_next = idx_last ? CNT_W'(1) : idx_inc;
            end
            S_P2_RD: begin
                if (skip) begin
                    idx_next = idx_inc;
                end
            end
            S_P2_LD: begin
                d_next    = pt;
                step_next = '0;
            end
            S_CROSS: begin
                step_next = step_reg + 4'd1;
                if (step_reg != '0) begin
                    if (!ptag_reg[0]) begin
                        vec_next[ptag_reg[2:1]] = pv;
                    end else begin
                        vec_next[ptag_reg[2:1]] = vec_reg[ptag_reg[2:1]] - pv;
                    end
                end
                if (step_reg == 4'(CROSS_STEPS)) begin
                    step_next    = '0;
                    sq_comp_next = '0;
                    sq_part_next = PART_HH;
                    ret_next     = S_P2_CMP;
                end
            end
            S_P2_CMP: begin
                if (p2_win) begin
                    bcross_next = acc_mag;
                    sec_next    = idx_reg;
                    bc_next     = vec_reg;
                end
                idx_next = idx_inc;
            end
            S_FIN: begin
                comp_next = '0;
                if (degen) begin
                    status_next = ST_DEGEN;
                end
            end
            S_DV_LD: begin
                vec_next[0]  = src;
                vec_next[1]  = '0;
                vec_next[2]  = '0;
                step_next    = '0;
                sq_comp_next = '0;
                sq_part_next = PART_HH;
                ret_next     = S_DV_SET;
            end
            S_DV_SET: begin
                rem_next = REM_W'(acc_mag);
                div_next = (comp_reg < 3'd3) ? best_reg : bcross_reg;
                quo_next = '0;
                bit_next = '0;
            end
            S_DIV: begin
                rem_next = ge ? trial - {1'b0, div_reg} : trial;
                quo_next = {quo_reg[QUO_W-2:0], ge};
                bit_next = bit_reg + 6'd1;
            end
            S_RT_SET: begin
                op_next  = {1'b0, quo_reg};
                res_next = '0;
                one_next = ROOT_W'(1) << (ROOT_W - 2);
                bit_next = '0;
            end
            S_ROOT: begin
                if (op_reg >= rsum) begin
                    op_next  = op_reg - rsum;
                    res_next = (res_reg >> 1) + one_reg;
                end else begin
                    res_next = res_reg >> 1;
                end
                one_next = one_reg >> 2;
                bit_next = bit_reg + 6'd1;
                if (bit_reg == 6'(ROOT_STEPS - 1)) begin
                    // rounded half of the root, signed as the source
                    rnd = {1'b0, res_next[32:0]} + 34'd1;
                    unit_next[comp_reg] = src[VEC_W-1] ? -$signed(rnd[32:1])
                                                       : $signed(rnd[32:1]);
                    comp_next = comp_reg + 3'd1;
                end
            end
            default: begin
                comp_next = comp_reg;
            end
        endcase
    end

    // control outputs
    always_comb begin
        ctl.pop  = (state_reg == S_IDLE) && job.valid;
        ctl.done = (state_reg == S_STORE_OUT) && out_free;
        rd_addr  = idx_reg[IDX_W-1:0];
        m_tvalid = out_valid_reg;
        m_tdata  = out_data_reg;
        m_tuser  = out_status_reg;
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (ctl.done) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath and output registers
    always_ff @(posedge aclk) begin
        ret_reg     <= ret_next;
        idx_reg     <= idx_next;
        cnt_reg     <= cnt_next;
        far_reg     <= far_next;
        sec_reg     <= sec_next;
        org_reg     <= org_next;
        d_reg       <= d_next;
        d1_reg      <= d1_next;
        vec_reg     <= vec_next;
        bc_reg      <= bc_next;
        unit_reg    <= unit_next;
        best_reg    <= best_next;
        bcross_reg  <= bcross_next;
        acc_reg     <= acc_next;
        step_reg    <= step_next;
        sq_comp_reg <= sq_comp_next;
        sq_part_reg <= sq_part_next;
        ppart_reg   <= sq_part_reg;
        ptag_reg    <= step_reg;
        prod_reg    <= mul_a * mul_b;
        rem_reg     <= rem_next;
        div_reg     <= div_next;
        quo_reg     <= quo_next;
        bit_reg     <= bit_next;
        op_reg      <= op_next;
        res_reg     <= res_next;
        one_reg     <= one_next;
        comp_reg    <= comp_next;
        status_reg  <= status_next;
        if (ctl.done) begin
            out_data_reg   <= {unit_reg[5], unit_reg[4], unit_reg[3],
                               unit_reg[2], unit_reg[1], unit_reg[0],
                               org_reg[2], org_reg[1], org_reg[0]};
            out_status_reg <= status_reg;
        end
    end

endmodule

// ----- design/plane_frame_from_points.sv -----
`timescale 1ns / 1ps
// plane_frame_from_points: top level, point loader in front of the frame engine
// depends on pff_pkg, pff_front and pff_back
//
//  channel | direction | tdata (low bit up)                          | tuser  | tlast
//  s_      | in        | point_x, point_y, point_z                   | -      | last_point
//  m_      | out       | origin_x/y/z, axis_x/y/z, normal_x/y/z      | status | -
//
// points load one per cycle while s_tready is high; after the last point the engine runs
// the farthest-point search and then the cross-product search over the stored points, and
// then works out the six unit components one at a time with the one shared 34x34
// multiplier, the bit-serial divider and square root.
// s_tready drops from the last point until the frame moves to the output register.
// reset is synchronous on aresetn low; the output register holds while m_tready is low.
module plane_frame_from_points import pff_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [PT_W-1:0]     s_tdata,   // point_x, point_y, point_z
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_W-1:0]    m_tdata,   // origin_x..z, axis_x..z, normal_x..z
    output logic [STATUS_W-1:0] m_tuser    // status
);

    job_t              job;
    back_ctl_t         ctl;
    logic [IDX_W-1:0]  rd_addr;
    logic [PT_W-1:0]   rd_data;

    // point loader and store
    pff_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .job      (job),
        .ctl      (ctl),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

    // frame engine
    pff_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .job      (job),
        .ctl      (ctl),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ----- tb/tb_plane_frame_from_points.sv -----
`timescale 1ns / 1ps
// tb_plane_frame_from_points: self-checking bench for the plane frame block
// depends on pff_pkg and plane_frame_from_points; streams point sets, predicts each frame
module tb_plane_frame_from_points import pff_pkg::*;;

    localparam int  LIMIT_CYCLES = 4000000;
    localparam int  TAIL_CYCLES  = 3000;
    localparam int  CW           = 32;

    // one wide 3-vector used by the frame predictor
    typedef struct packed {
        logic signed [127:0] x;
        logic signed [127:0] y;
        logic signed [127:0] z;
    } wvec_t;

    // one frame: origin x..z, axis x..z, normal x..z, then status
    typedef struct {
        logic [8:0][CW-1:0] w;
        status_t            st;
    } frame_t;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [PT_W-1:0]     s_tdata;
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_W-1:0]    m_tdata;
    logic [STATUS_W-1:0] m_tuser;

    plane_frame_from_points uut (.*);

    // bench state
    logic signed [CW-1:0] set_x[$], set_y[$], set_z[$];
    frame_t               frames_due[$];
    int                   src_idle_pct;
    int                   snk_stall_pct;
    int                   stall_request;
    int                   stall_left;
    int                   mismatches;
    int                   frames_seen;
    int                   points_sent;
    int                   cycles;
    string                field_name[9] = '{"origin_x", "origin_y", "origin_z",
                                            "axis_x", "axis_y", "axis_z",
                                            "normal_x", "normal_y", "normal_z"};

    // clock
    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // ---------------- frame predictor ----------------

    function automatic logic [255:0] abs_w(input logic signed [127:0] v);
        logic [127:0] m;
        m = v < 0 ? -v : v;
        return {128'd0, m};
    endfunction

    function automatic logic [255:0] square_len(input wvec_t v);
        logic [255:0] a, b, c;
        a = abs_w(v.x);
        b = abs_w(v.y);
        c = abs_w(v.z);
        return a * a + b * b + c * c;
    endfunction

    function automatic wvec_t point_offset(input int i);
        wvec_t d;
        logic signed [127:0] px, py, pz, ox, oy, oz;
        px = set_x[i]; py = set_y[i]; pz = set_z[i];
        ox = set_x[0]; oy = set_y[0]; oz = set_z[0];
        d.x = px - ox;
        d.y = py - oy;
        d.z = pz - oz;
        return d;
    endfunction

    function automatic wvec_t cross_of(input wvec_t a, input wvec_t b);
        wvec_t c;
        c.x = a.y * b.z - a.z * b.y;
        c.y = a.z * b.x - a.x * b.z;
        c.z = a.x * b.y - a.y * b.x;
        return c;
    endfunction

    // |v| * 2^30 / sqrt(s), nearest with halves away from zero, sign of v
    function automatic logic [CW-1:0] unit_part(input logic signed [127:0] v,
                                                input logic [255:0] s);
        logic [255:0] t, lo, hi, mid, h;
        t  = abs_w(v);
        t  = (t * t) << 60;
        lo = 0;
        hi = 256'd1 << 30;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            if (mid * mid * s <= t) lo = mid;
            else hi = mid - 1;
        end
        h = 2 * lo + 1;
        if (h * h * s <= (t << 2)) lo = lo + 1;
        return v < 0 ? -lo[CW-1:0] : lo[CW-1:0];
    endfunction

    function automatic frame_t predict_frame();
        frame_t       f;
        int           n, far_i, sec_i;
        logic [255:0] best_len, best_cross, s;
        wvec_t        d1, d2, c;
        n = set_x.size();
        f.w = '0;
        f.w[0] = set_x[0];
        f.w[1] = set_y[0];
        f.w[2] = set_z[0];
        f.st = ST_OK;
        far_i = 0; sec_i = 0; best_len = 0; best_cross = 0;
        if (n < MIN_POINTS) begin
            f.st = ST_FEW;
            return f;
        end
        // farthest point from the origin, earliest on a tie
        for (int i = 1; i < n; i++) begin
            s = square_len(point_offset(i));
            if (i == 1 || s > best_len) begin
                best_len = s;
                far_i = i;
            end
        end
        d1 = point_offset(far_i);
        // farthest point from the line along the axis
        for (int i = 1; i < n; i++) begin
            if (i != far_i) begin
                s = square_len(cross_of(d1, point_offset(i)));
                if (sec_i == 0 || s > best_cross) begin
                    best_cross = s;
                    sec_i = i;
                end
            end
        end
        if (best_len == 0 || best_cross == 0) begin
            f.st = ST_DEGEN;
            return f;
        end
        d2 = point_offset(sec_i);
        c  = cross_of(d1, d2);
        f.w[3] = unit_part(d1.x, best_len);
        f.w[4] = unit_part(d1.y, best_len);
        f.w[5] = unit_part(d1.z, best_len);
        f.w[6] = unit_part(c.x, best_cross);
        f.w[7] = unit_part(c.y, best_cross);
        f.w[8] = unit_part(c.z, best_cross);
        return f;
    endfunction

    // ---------------- input side ----------------

    task automatic send_point(input logic [CW-1:0] x, input logic [CW-1:0] y,
                              input logic [CW-1:0] z, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= {$urandom, $urandom, $urandom};
            s_tlast  <= $urandom_range(1);
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        points_sent++;
        // stored points stop at the store depth, the last mark still counts
        if (set_x.size() < MAX_POINTS) begin
            set_x.push_back(x);
            set_y.push_back(y);
            set_z.push_back(z);
        end
        if (last) begin
            frames_due.push_back(predict_frame());
            set_x.delete();
            set_y.delete();
            set_z.delete();
        end
    endtask

    function automatic logic [CW-1:0] rand_coord(input int kind);
        case (kind)
            0:       return $urandom;
            1:       return $urandom_range(7) - 3;
            2:       return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return $urandom_range(65535) - 32768;
        endcase
    endfunction

    // one random point set of the given size, shaped by a random style
    task automatic send_random_set(input int n);
        int style, kind;
        logic signed [CW-1:0] ox, oy, oz, dx, dy, dz, k;
        style = $urandom_range(9);
        kind  = $urandom_range(3);
        ox = rand_coord(kind); oy = rand_coord(kind); oz = rand_coord(kind);
        dx = $urandom_range(200) - 100;
        dy = $urandom_range(200) - 100;
        dz = $urandom_range(200) - 100;
        for (int i = 0; i < n; i++) begin
            if (i == 0) begin
                send_point(ox, oy, oz, n == 1);
            end else if (style == 0) begin
                // all points on the origin
                send_point(ox, oy, oz, i == n - 1);
            end else if (style == 1) begin
                // all points on one line through the origin
                k = $urandom_range(2000) - 1000;
                send_point(ox + k * dx, oy + k * dy, oz + k * dz, i == n - 1);
            end else if (style == 2) begin
                // repeated corner points give ties
                k = $urandom_range(1) ? 5 : -5;
                send_point(ox + k, oy, oz + ($urandom_range(1) ? k : 0), i == n - 1);
            end else begin
                send_point(rand_coord(kind), rand_coord(kind), rand_coord(kind),
                           i == n - 1);
            end
        end
    endtask

    // ---------------- output side ----------------

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else begin
            frame_t exp_f;
            // long hold-off when asked, else random stalls
            if (stall_request > 0) begin
                stall_left    <= stall_request;
                stall_request = 0;
                m_tready      <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_tready   <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= snk_stall_pct);
            end
            // compare each frame transaction with the oldest prediction
            if (m_tvalid && m_tready) begin
                frames_seen++;
                if (frames_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected frame at cycle %0d", cycles);
                end else begin
                    exp_f = frames_due.pop_front();
                    for (int k = 0; k < 9; k++) begin
                        if (m_tdata[CW*k +: CW] !== exp_f.w[k]) begin
                            mismatches++;
                            if (mismatches <= 10)
                                $display("frame %0d %s: expected %0d got %0d",
                                         frames_seen, field_name[k],
                                         $signed(exp_f.w[k]),
                                         $signed(m_tdata[CW*k +: CW]));
                        end
                    end
                    if (m_tuser !== exp_f.st) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("frame %0d status: expected %0d got %0d",
                                     frames_seen, exp_f.st, m_tuser);
                    end
                end
            end
        end
    end

    // ---------------- tests ----------------

    task automatic test_directed();
        // one and two points, too few
        send_point(32'h7fff_ffff, 32'h8000_0000, 32'd5, 1'b1);
        send_point(32'd1, 32'd2, 32'd3, 1'b0);
        send_point(32'd4, 32'd5, 32'd6, 1'b1);
        // coincident points
        send_point(32'd9, 32'd9, 32'd9, 1'b0);
        send_point(32'd9, 32'd9, 32'd9, 1'b0);
        send_point(32'd9, 32'd9, 32'd9, 1'b1);
        // collinear points
        send_point(32'd0, 32'd0, 32'd0, 1'b0);
        send_point(32'd3, -32'sd6, 32'd9, 1'b0);
        send_point(-32'sd1, 32'd2, -32'sd3, 1'b1);
        // plain unit triangle
        send_point(32'd0, 32'd0, 32'd0, 1'b0);
        send_point(32'h0001_0000, 32'd0, 32'd0, 1'b0);
        send_point(32'd0, 32'h0001_0000, 32'd0, 1'b1);
        // extreme coordinates on every field
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
        send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
        send_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
        send_point(32'hffff_ffff, 32'h0000_0000, 32'h8000_0000, 1'b1);
        // equal lengths in both searches, though each search has a single farthest point
        send_point(32'd0, 32'd0, 32'd0, 1'b0);
        send_point(32'd2, 32'd0, 32'd0, 1'b0);
        send_point(-32'sd2, 32'd0, 32'd0, 1'b0);
        send_point(32'd0, 32'd3, 32'd0, 1'b0);
        send_point(32'd0, 32'd0, 32'd3, 1'b0);
        send_point(32'd1, -32'sd3, 32'd0, 1'b1);
    endtask

    task automatic test_random_phase(input int src_pct, input int snk_pct, input int items);
        int start;
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        start = points_sent;
        while (points_sent - start < items)
            send_random_set($urandom_range(9) == 0 ? $urandom_range(1, 2)
                                                   : $urandom_range(3, 8));
    endtask

    task automatic test_output_hold();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        stall_request = 2500;
        for (int i = 0; i < 6; i++)
            send_random_set($urandom_range(3, 6));
    endtask

    task automatic test_store_full();
        src_idle_pct  = 0;
        snk_stall_pct = 10;
        send_random_set(MAX_POINTS + 7);
    endtask

    initial begin
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tlast       = 1'b0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        stall_request = 0;
        mismatches    = 0;
        frames_seen   = 0;
        points_sent   = 0;
        cycles        = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_phase(0, 0, 12);
        test_random_phase(71, 0, 12);
        test_random_phase(0, 71, 12);
        test_random_phase(10, 10, 12);
        test_output_hold();
        test_store_full();

        s_tvalid <= 1'b0;
        while (frames_due.size() > 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("sent %0d points, checked %0d frames over directed, random, hold-off",
                 points_sent, frames_seen);
        $display("and full-store sets, with %0d mismatches", mismatches);
        if (mismatches == 0 && frames_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- files.f -----
design/pff_pkg.sv
design/pff_front.sv
design/pff_back.sv
design/plane_frame_from_points.sv
tb/tb_plane_frame_from_points.sv
